[src/lbad_pkg.sv]
// ----------------------------------------------------------------------------
// lbad_pkg
// Shared types and constants for the line box average decimator.
// ----------------------------------------------------------------------------
package lbad_pkg;

  localparam int unsigned CH_W          = 8;
  localparam int unsigned SUM_W         = 16;
  localparam int unsigned NUM_CH        = 3;
  localparam int unsigned MAX_GROUP_DEF = 255;
  localparam logic [7:0]  GROUP_RESET   = 8'd2;

  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
    logic            line_end;
  } in_pixel_t;

  typedef struct packed {
    logic [CH_W-1:0] red_avg;
    logic [CH_W-1:0] green_avg;
    logic [CH_W-1:0] blue_avg;
    logic            line_done;
  } out_pixel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic div_step;
    logic load_out;
  } lbad_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic close;
  } lbad_sts_t;

endpackage

[src/lbad_ctrl.sv]
// ----------------------------------------------------------------------------
// lbad_ctrl
// Controller: accepts pixels, sequences the divider and fills the output slot.
// ----------------------------------------------------------------------------
module lbad_ctrl
  import lbad_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      src_valid,
  output logic      src_ready,
  output logic      dst_valid,
  input  logic      dst_ready,
  input  lbad_sts_t sts,
  output lbad_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [2:0] step;
  logic       slot_free;

  assign src_ready = (state == ST_IDLE);
  assign slot_free = !dst_valid || dst_ready;

  always_comb begin
    state_next   = state;
    cmd.accept   = 1'b0;
    cmd.div_step = 1'b0;
    cmd.load_out = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd.accept = src_valid;
        if (src_valid && sts.close) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step == 3'd7) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= 3'd0;
      dst_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.div_step) begin
        step <= step + 3'd1;
      end else begin
        step <= 3'd0;
      end
      if (cmd.load_out) begin
        dst_valid <= 1'b1;
      end else if (dst_ready) begin
        dst_valid <= 1'b0;
      end
    end
  end

endmodule

[src/lbad_dp.sv]
// ----------------------------------------------------------------------------
// lbad_dp
// Datapath: channel accumulators, run counter, three restoring dividers
// sharing one schedule, and the output register.
// ----------------------------------------------------------------------------
module lbad_dp
  import lbad_pkg::*;
#(
  parameter int unsigned MAX_GROUP = MAX_GROUP_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  in_pixel_t  src_pixel,
  input  lbad_cmd_t  cmd,
  output lbad_sts_t  sts,
  output out_pixel_t dst_pixel
);

  localparam logic [7:0] GROUP_CAP = (MAX_GROUP > 255) ? 8'd255 : 8'(MAX_GROUP);

  logic [7:0]                     group_size;
  logic [7:0]                     eff_group;
  logic [7:0]                     run_count;
  logic [8:0]                     count;
  logic [NUM_CH-1:0][SUM_W-1:0]   sum;
  logic [NUM_CH-1:0][SUM_W-1:0]   sum_next;
  logic [NUM_CH-1:0][CH_W-1:0]    pix;
  logic [NUM_CH-1:0][SUM_W-1:0]   rem;
  logic [NUM_CH-1:0][CH_W-1:0]    quo;
  logic [NUM_CH-1:0]              ge;
  logic [SUM_W-2:0]               div_shift;
  logic                           last_flag;

  assign pix = {src_pixel.red_in, src_pixel.green_in, src_pixel.blue_in};

  always_comb begin
    if (group_size == 8'd0) begin
      eff_group = 8'd1;
    end else if (group_size > GROUP_CAP) begin
      eff_group = GROUP_CAP;
    end else begin
      eff_group = group_size;
    end
  end

  // A run never holds more than 255 pixels, so the count fits in eight bits
  // once the run has closed.
  assign count     = {1'b0, run_count} + 9'd1;
  assign sts.close = (count >= {1'b0, eff_group}) || src_pixel.line_end;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      sum_next[c] = sum[c] + {{(SUM_W-CH_W){1'b0}}, pix[c]};
      ge[c]       = rem[c] >= {1'b0, div_shift};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= GROUP_RESET;
      run_count  <= 8'd0;
      sum        <= '0;
    end else begin
      if (cfg_we) begin
        group_size <= cfg_wdata;
      end
      if (cmd.accept) begin
        if (sts.close) begin
          run_count <= 8'd0;
          sum       <= '0;
        end else begin
          run_count <= count[7:0];
          sum       <= sum_next;
        end
      end
    end
  end

  // The quotient is below 256 because every sum is at most 255 times its
  // count, so eight compare-and-subtract steps from the top bit suffice.
  always_ff @(posedge clk) begin
    if (cmd.accept && sts.close) begin
      rem       <= sum_next;
      quo       <= '0;
      div_shift <= {count[7:0], 7'd0};
      last_flag <= src_pixel.line_end;
    end else if (cmd.div_step) begin
      for (int c = 0; c < NUM_CH; c++) begin
        if (ge[c]) begin
          rem[c] <= rem[c] - {1'b0, div_shift};
        end
        quo[c] <= {quo[c][CH_W-2:0], ge[c]};
      end
      div_shift <= div_shift >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      dst_pixel.red_avg   <= quo[2];
      dst_pixel.green_avg <= quo[1];
      dst_pixel.blue_avg  <= quo[0];
      dst_pixel.line_done <= last_flag;
    end
  end

endmodule

[src/line_box_average_decimator_core.sv]
// ----------------------------------------------------------------------------
// line_box_average_decimator_core
// Box-filter downscaler for one line of RGB pixels.
// ----------------------------------------------------------------------------
// Pixels of a line are summed per channel in runs of group_size (zero acts as
// one, values above MAX_GROUP are clamped); a run closes when it is full or at
// the pixel flagged line_end, and one pixel holding the truncated mean of each
// channel is sent out. A pixel that does not close a run is taken at once.
// A pixel that closes a run starts a shared eight-step restoring divider,
// and no further pixel is taken until the divider has finished and its
// result has been loaded into the output slot, which waits until the previous
// result has been transferred; a waiting result thus holds up the next run.
module line_box_average_decimator_core
  import lbad_pkg::*;
#(
  parameter int unsigned MAX_GROUP = MAX_GROUP_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       src_valid,
  output logic       src_ready,
  input  in_pixel_t  src_pixel,
  output logic       dst_valid,
  input  logic       dst_ready,
  output out_pixel_t dst_pixel
);

  lbad_cmd_t cmd;
  lbad_sts_t sts;

  lbad_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lbad_dp #(
    .MAX_GROUP (MAX_GROUP)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .src_pixel (src_pixel),
    .cmd       (cmd),
    .sts       (sts),
    .dst_pixel (dst_pixel)
  );

  // A new result never overwrites one that has not been transferred.
  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!dst_valid || dst_ready))
    else $error("result loaded over a pending result");

  // A pixel that closes a run blocks input while the divider runs.
  a_close_blocks: assert property (@(posedge clk) disable iff (rst)
    (src_valid && src_ready && sts.close) |=> !src_ready)
    else $error("input taken while divider busy");

  // Output valid only rises after a result load.
  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(dst_valid) |-> $past(cmd.load_out))
    else $error("output valid without a loaded result");

endmodule
